>>> sv/fpme_pkg.sv
// Package: shared constants for the front panel mode and encoder core.
`default_nettype none
package fpme_pkg;
  // number of modes in the cycle, normal mode included
  localparam int MODE_COUNT = 12;
  // upper limit of the setting value, half units
  localparam int VALUE_MAX = 200;

  localparam int MODE_W = 4;
  localparam int VALUE_W = 8;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W = 17;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [MODE_W-1:0] MODE_NORMAL = '0;
  localparam logic [MODE_W-1:0] MODE_FIRST = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LAST = MODE_W'(MODE_COUNT - 1);
  localparam logic [VALUE_W-1:0] VALUE_TOP = VALUE_W'(VALUE_MAX);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] MODE_STEP_RST = 16'd1000;
  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd10000;
endpackage
`default_nettype wire

>>> sv/front_panel_mode_and_encoder_core.sv
// Top level: debounced mode button, mode cycling with idle timeout, encoder setting value.
`default_nettype none
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | in        | in_valid / in_ready  | button_level, enc_a_level, enc_b_level
//  out     | out       | out_valid/ out_ready | current_mode, status_led, setting_value,
//          |           |                      | value_changed, settings_dirty, redraw
//  cfg     | in        | cfg_valid/ cfg_ready | cfg_index, cfg_data (always ready)
//
//  One word per cycle sustained while the output is not stalled. A word is held in the
//  input register, then the tick update (counters, debounce, mode step, timeout, encoder)
//  runs in one pass and lands in the output register.
//  rst (synchronous) brings back the power-up state and the default timing registers.
//  A stalled output holds the tick stage; the input register then holds and in_ready drops.
module front_panel_mode_and_encoder_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          button_level,
  input  wire logic                          enc_a_level,
  input  wire logic                          enc_b_level,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fpme_pkg::MODE_W-1:0]        current_mode,
  output logic                               status_led,
  output logic [fpme_pkg::VALUE_W-1:0]       setting_value,
  output logic                               value_changed,
  output logic                               settings_dirty,
  output logic                               redraw,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fpme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpme_pkg::CFG_W-1:0]    cfg_data
);

  // timing registers
  logic [fpme_pkg::CFG_W-1:0] debounce_ticks;
  logic [fpme_pkg::CFG_W-1:0] mode_step_ticks;
  logic [fpme_pkg::CFG_W-1:0] idle_timeout_ticks;

  // input register
  logic s1_valid;
  logic s1_btn;
  logic s1_a;
  logic s1_b;

  // panel state
  logic [fpme_pkg::MODE_W-1:0]  mode_reg;
  logic                         last_raw_button;
  logic                         stable_button;
  logic [fpme_pkg::CNT_W-1:0]   since_button_change;
  logic [fpme_pkg::CNT_W-1:0]   since_mode_step;
  logic [fpme_pkg::CNT_W-1:0]   since_activity;
  logic                         a_latched;
  logic                         b_latched;
  logic [fpme_pkg::VALUE_W-1:0] value_reg;
  logic                         dirty_flag;

  // next values
  logic [fpme_pkg::MODE_W-1:0]  mode_reg_next;
  logic                         stable_button_next;
  logic [fpme_pkg::CNT_W-1:0]   since_button_change_next;
  logic [fpme_pkg::CNT_W-1:0]   since_mode_step_next;
  logic [fpme_pkg::CNT_W-1:0]   since_activity_next;
  logic                         a_latched_next;
  logic                         b_latched_next;
  logic [fpme_pkg::VALUE_W-1:0] value_reg_next;
  logic                         dirty_flag_next;
  logic                         changed;

  logic advance;  // tick stage moves its word into the output register

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= fpme_pkg::DEBOUNCE_RST;
      mode_step_ticks    <= fpme_pkg::MODE_STEP_RST;
      idle_timeout_ticks <= fpme_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpme_pkg::REG_DEBOUNCE:     debounce_ticks     <= cfg_data;
        fpme_pkg::REG_MODE_STEP:    mode_step_ticks    <= cfg_data;
        fpme_pkg::REG_IDLE_TIMEOUT: idle_timeout_ticks <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_btn <= button_level;
      s1_a   <= enc_a_level;
      s1_b   <= enc_b_level;
    end
  end

  // one tick: counters, button, timeout, encoder A, then encoder B
  always_comb begin
    since_button_change_next = (since_button_change == fpme_pkg::CNT_MAX) ?
                               since_button_change : since_button_change + 1'b1;
    since_mode_step_next     = (since_mode_step == fpme_pkg::CNT_MAX) ?
                               since_mode_step : since_mode_step + 1'b1;
    since_activity_next      = (since_activity == fpme_pkg::CNT_MAX) ?
                               since_activity : since_activity + 1'b1;
    mode_reg_next      = mode_reg;
    stable_button_next = stable_button;
    a_latched_next     = a_latched;
    b_latched_next     = b_latched;
    value_reg_next     = value_reg;
    dirty_flag_next    = dirty_flag;
    changed            = 1'b0;

    // debounce
    if (s1_btn != last_raw_button) begin
      since_button_change_next = '0;
    end
    if (since_button_change_next > {1'b0, debounce_ticks}) begin
      stable_button_next = s1_btn;
    end

    // held button (active low) keeps the panel awake and steps the mode
    if (!stable_button_next) begin
      since_activity_next = '0;
      if (since_mode_step_next > {1'b0, mode_step_ticks}) begin
        if (mode_reg >= fpme_pkg::MODE_FIRST && mode_reg < fpme_pkg::MODE_LAST) begin
          mode_reg_next = mode_reg + 1'b1;
        end else begin
          mode_reg_next = fpme_pkg::MODE_FIRST;
        end
        since_mode_step_next = '0;
      end
    end

    // idle timeout back to normal
    if (since_activity_next > {1'b0, idle_timeout_ticks} &&
        mode_reg_next != fpme_pkg::MODE_NORMAL) begin
      mode_reg_next = fpme_pkg::MODE_NORMAL;
    end

    // encoder counts only in setup modes; latches frozen in normal mode
    if (mode_reg_next != fpme_pkg::MODE_NORMAL) begin
      if (s1_a != a_latched) begin
        a_latched_next = s1_a;
        if (s1_a && !b_latched) begin
          since_activity_next = '0;
          dirty_flag_next     = 1'b1;
          if (value_reg < fpme_pkg::VALUE_TOP) begin
            value_reg_next = value_reg + 1'b1;
            changed        = 1'b1;
          end
        end
      end
      if (s1_b != b_latched) begin
        b_latched_next = s1_b;
        // sees A's updated latch and value
        if (s1_b && !a_latched_next) begin
          since_activity_next = '0;
          dirty_flag_next     = 1'b1;
          if (value_reg_next != '0) begin
            value_reg_next = value_reg_next - 1'b1;
            changed        = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg            <= fpme_pkg::MODE_NORMAL;
      last_raw_button     <= 1'b1;
      stable_button       <= 1'b1;
      since_button_change <= '0;
      since_mode_step     <= '0;
      since_activity      <= '0;
      a_latched           <= 1'b0;
      b_latched           <= 1'b0;
      value_reg           <= '0;
      dirty_flag          <= 1'b0;
    end else if (advance) begin
      mode_reg            <= mode_reg_next;
      last_raw_button     <= s1_btn;
      stable_button       <= stable_button_next;
      since_button_change <= since_button_change_next;
      since_mode_step     <= since_mode_step_next;
      since_activity      <= since_activity_next;
      a_latched           <= a_latched_next;
      b_latched           <= b_latched_next;
      value_reg           <= value_reg_next;
      dirty_flag          <= dirty_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      current_mode   <= mode_reg_next;
      status_led     <= (mode_reg_next == fpme_pkg::MODE_NORMAL);
      setting_value  <= value_reg_next;
      value_changed  <= changed;
      settings_dirty <= dirty_flag_next;
      redraw         <= (mode_reg_next != mode_reg);
    end
  end

endmodule
`default_nettype wire

>>> bench/fpme_panel_checker.sv
// Checker for the front panel core: watches all three channels, predicts each output word, compares.
`timescale 1ns / 1ps
module fpme_panel_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              button_level,
  input  logic                              enc_a_level,
  input  logic                              enc_b_level,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [fpme_pkg::MODE_W-1:0]       current_mode,
  input  logic                              status_led,
  input  logic [fpme_pkg::VALUE_W-1:0]      setting_value,
  input  logic                              value_changed,
  input  logic                              settings_dirty,
  input  logic                              redraw,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [fpme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpme_pkg::CFG_W-1:0]        cfg_data,
  output int                                mismatches,
  output int                                pending
);
  import fpme_pkg::*;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               led;
    logic [VALUE_W-1:0] value;
    logic               changed;
    logic               dirty;
    logic               redraw;
  } panel_word_t;

  panel_word_t expected_words[$];

  // timing registers as last written
  logic [CFG_W-1:0]   debounce_cfg, step_cfg, idle_cfg;

  // panel state
  logic [MODE_W-1:0]  mode_q;
  logic               raw_btn_q, stable_btn_q;
  logic [CNT_W-1:0]   btn_age, step_age, idle_age;
  logic               a_lat, b_lat;
  logic [VALUE_W-1:0] value_q;
  logic               dirty_q;

  function automatic logic [CNT_W-1:0] age_up(logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  // one millisecond tick: counters, button, timeout, then encoder A and B
  function automatic panel_word_t panel_tick(logic btn, logic a, logic b);
    panel_word_t w;
    logic [MODE_W-1:0] prev_mode;
    logic moved;
    prev_mode = mode_q;
    moved = 1'b0;
    btn_age = age_up(btn_age);
    step_age = age_up(step_age);
    idle_age = age_up(idle_age);

    if (btn != raw_btn_q)
      btn_age = '0;
    if (btn_age > {1'b0, debounce_cfg})
      stable_btn_q = btn;
    if (!stable_btn_q) begin
      idle_age = '0;
      if (step_age > {1'b0, step_cfg}) begin
        mode_q = (mode_q >= MODE_FIRST && mode_q < MODE_LAST) ? mode_q + 1'b1 : MODE_FIRST;
        step_age = '0;
      end
    end
    raw_btn_q = btn;

    if (idle_age > {1'b0, idle_cfg} && mode_q != MODE_NORMAL)
      mode_q = MODE_NORMAL;

    // latches freeze in normal mode
    if (mode_q != MODE_NORMAL) begin
      if (a != a_lat) begin
        a_lat = a;
        if (a_lat && !b_lat) begin
          idle_age = '0;
          if (value_q < VALUE_TOP) begin
            value_q = value_q + 1'b1;
            moved = 1'b1;
          end
          dirty_q = 1'b1;
        end
      end
      if (b != b_lat) begin
        b_lat = b;
        if (b_lat && !a_lat) begin
          idle_age = '0;
          if (value_q != '0) begin
            value_q = value_q - 1'b1;
            moved = 1'b1;
          end
          dirty_q = 1'b1;
        end
      end
    end

    w.mode = mode_q;
    w.led = (mode_q == MODE_NORMAL);
    w.value = value_q;
    w.changed = moved;
    w.dirty = dirty_q;
    w.redraw = (mode_q != prev_mode);
    return w;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    panel_word_t want;
    if (rst) begin
      debounce_cfg = DEBOUNCE_RST;
      step_cfg = MODE_STEP_RST;
      idle_cfg = IDLE_TIMEOUT_RST;
      mode_q = MODE_NORMAL;
      raw_btn_q = 1'b1;
      stable_btn_q = 1'b1;
      btn_age = '0;
      step_age = '0;
      idle_age = '0;
      a_lat = 1'b0;
      b_lat = 1'b0;
      value_q = '0;
      dirty_q = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:     debounce_cfg = cfg_data;
          REG_MODE_STEP:    step_cfg = cfg_data;
          REG_IDLE_TIMEOUT: idle_cfg = cfg_data;
          default: ;
        endcase
      end
      // output first: a word leaving now belongs to an older tick
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("output word with none expected: mode %0d value %0d",
                 current_mode, setting_value);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("current_mode", want.mode, current_mode);
          check_field("status_led", want.led, status_led);
          check_field("setting_value", want.value, setting_value);
          check_field("value_changed", want.changed, value_changed);
          check_field("settings_dirty", want.dirty, settings_dirty);
          check_field("redraw", want.redraw, redraw);
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(panel_tick(button_level, enc_a_level, enc_b_level));
    end
    pending = expected_words.size();
  end
endmodule

>>> bench/tb_front_panel_mode_and_encoder_core.sv
// Testbench top: drives ticks, timing writes and output stalls; checker judges the words.
`timescale 1ns / 1ps
module tb_front_panel_mode_and_encoder_core;
  import fpme_pkg::*;

  // pause before a timing write or the verdict; a result passes the input and output registers
  localparam int SETTLE_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 button_level = 1'b1;
  logic                 enc_a_level = 1'b0;
  logic                 enc_b_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [MODE_W-1:0]    current_mode;
  logic                 status_led;
  logic [VALUE_W-1:0]   setting_value;
  logic                 value_changed;
  logic                 settings_dirty;
  logic                 redraw;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data = '0;

  int                   mismatches;
  int                   pending;
  int unsigned          ticks_sent = 0;
  // set per episode: no gaps and no stalls on either side
  bit                   steady = 1'b0;

  always #1 clk = ~clk;

  front_panel_mode_and_encoder_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .button_level(button_level), .enc_a_level(enc_a_level), .enc_b_level(enc_b_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .current_mode(current_mode), .status_led(status_led), .setting_value(setting_value),
    .value_changed(value_changed), .settings_dirty(settings_dirty), .redraw(redraw),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fpme_panel_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .button_level(button_level), .enc_a_level(enc_a_level), .enc_b_level(enc_b_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .current_mode(current_mode), .status_led(status_led), .setting_value(setting_value),
    .value_changed(value_changed), .settings_dirty(settings_dirty), .redraw(redraw),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  // One tick word. Entered just after an accepting edge (or at start); the first
  // falling edge either drops valid for a gap or puts up the next word directly.
  task automatic send_tick(input logic btn, input logic a, input logic b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    button_level <= btn;
    enc_a_level <= a;
    enc_b_level <= b;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // Stop sending and let every expected word come out, then pause for SETTLE_CYCLES.
  task automatic settle_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all three timing registers back to back once the core is idle.
  task automatic write_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] step,
                              input logic [CFG_W-1:0] idle);
    logic [CFG_IDX_W-1:0] regs [3];
    logic [CFG_W-1:0]     vals [3];
    regs = '{REG_DEBOUNCE, REG_MODE_STEP, REG_IDLE_TIMEOUT};
    vals = '{deb, step, idle};
    settle_words();
    for (int i = 0; i < 3; i++) begin
      if (i > 0) @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random episodes until about n more ticks have gone in. Mostly well-formed
  // presses and encoder turns so setup modes, timeouts and limits get exercised;
  // the rest is raw noise and contact bounce.
  task automatic run_random(input int unsigned n);
    int unsigned target, r, len, dir;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 2) begin
        // held press, encoder mostly still, sometimes jostled
        len = $urandom_range(1, 25);
        repeat (len)
          send_tick(1'b0,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : enc_a_level,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : enc_b_level);
        len = $urandom_range(1, 6);
        repeat (len) send_tick(1'b1, enc_a_level, enc_b_level);
      end else if (r < 5) begin
        // single-channel detents: A pulse counts up, B pulse counts down
        dir = $urandom_range(0, 1);
        len = $urandom_range(1, 15);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) dir = ~dir & 1;
          if (dir != 0) send_tick(1'b1, 1'b1, 1'b0);
          else          send_tick(1'b1, 1'b0, 1'b1);
          send_tick(1'b1, 1'b0, 1'b0);
        end
      end else if (r < 7) begin
        // full quadrature cycles, one counting edge per cycle
        dir = $urandom_range(0, 1);
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) dir = ~dir & 1;
          if (dir != 0) begin
            send_tick(1'b1, 1'b1, 1'b0);
            send_tick(1'b1, 1'b1, 1'b1);
            send_tick(1'b1, 1'b0, 1'b1);
          end else begin
            send_tick(1'b1, 1'b0, 1'b1);
            send_tick(1'b1, 1'b1, 1'b1);
            send_tick(1'b1, 1'b1, 1'b0);
          end
          send_tick(1'b1, 1'b0, 1'b0);
        end
      end else if (r == 7) begin
        len = $urandom_range(1, 10);
        repeat (len)
          send_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (r == 8) begin
        // quiet stretch, long enough to hit the idle timeout at small settings
        len = $urandom_range(1, 30);
        repeat (len) send_tick(1'b1, enc_a_level, enc_b_level);
      end else begin
        // bouncing contact settling into a press
        len = $urandom_range(3, 8);
        repeat (len) send_tick($urandom_range(0, 1), enc_a_level, enc_b_level);
        len = $urandom_range(1, 10);
        repeat (len) send_tick(1'b0, enc_a_level, enc_b_level);
      end
    end
  endtask

  // Output side: random stall before each word, held ready until it is taken.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset timing: button never debounces in a few ticks, encoder ignored in normal mode
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);

    // instant debounce and stepping, timeout at its maximum
    write_timing(16'd0, 16'd0, 16'hFFFF);
    // Held press walks every mode and wraps from the last back to the first.
    // A sits high against a low latch, so the first setup tick counts it as an edge.
    repeat (13) send_tick(1'b0, 1'b1, 1'b0);
    repeat (2) send_tick(1'b1, 1'b0, 1'b0);
    // down to zero, both channels high (no count), then a down edge at the floor
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    // climb past the upper limit: one up count per A pulse
    steady = 1'b0;
    repeat (206) begin
      send_tick(1'b1, 1'b1, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0);
    end
    run_random(20);

    write_timing(16'd2, 16'd3, 16'd20);
    run_random(70);
    // zero timeout: setup mode survives only while pressed
    write_timing(16'd0, 16'd2, 16'd0);
    run_random(40);
    write_timing(16'hFFFF, 16'hFFFF, 16'd1);
    run_random(20);
    repeat (2) begin
      write_timing($urandom_range(0, 4), $urandom_range(0, 20), $urandom_range(1, 50));
      run_random(50);
    end
    write_timing(16'd1, 16'd5, 16'd8);
    run_random(50);

    settle_words();
    if (mismatches == 0)
      $display("tb_front_panel_mode_and_encoder_core OK");
    else
      $display("tb_front_panel_mode_and_encoder_core NOT OK");
    $finish;
  end

  // far beyond the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("tb_front_panel_mode_and_encoder_core NOT OK");
    $finish;
  end
endmodule
